### design/dkm_pkg.sv
// ============================================================================
// dkm_pkg: shared constants of the difference key matte block
// Register indexes, register reset values and the default channel width.
// ============================================================================
`default_nettype none

package dkm_pkg;

    // Default channel width, unsigned fixed point with all bits fraction.
    localparam int CHANNEL_BITS_DEFAULT = 16;

    // Register reset values, about 0.1 at the default width.
    localparam int TOLERANCE_RESET = 6554;
    localparam int FALLOFF_RESET   = 6554;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FALLOFF   = 1'b1;

endpackage

`default_nettype wire

### design/dkm_div_pipe.sv
// ============================================================================
// dkm_div_pipe: pipelined restoring divider
// Each stage develops STEP_BITS quotient bits by compare and subtract; the
// dividend shifts out of the quotient register as quotient bits shift in.
// A payload word travels beside each beat; all stages advance on ce.
// ============================================================================
`default_nettype none

module dkm_div_pipe #(
    parameter int DEN_W     = 16,
    parameter int QUO_W     = 16,
    parameter int STEP_BITS = 1,
    parameter int PAY_W     = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             ce,
    input  wire logic             in_valid,
    input  wire logic [DEN_W-1:0] in_rem,
    input  wire logic [QUO_W-1:0] in_quo,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic [PAY_W-1:0] in_pay,
    output logic                  out_valid,
    output logic      [QUO_W-1:0] out_quo,
    output logic      [PAY_W-1:0] out_pay
);

    localparam int STAGES = QUO_W / STEP_BITS;

    logic             valid_reg [STAGES];
    logic [DEN_W-1:0] rem_reg   [STAGES];
    logic [QUO_W-1:0] quo_reg   [STAGES];
    logic [PAY_W-1:0] pay_reg   [STAGES];

    logic             src_valid [STAGES];
    logic [DEN_W-1:0] src_rem   [STAGES];
    logic [QUO_W-1:0] src_quo   [STAGES];
    logic [PAY_W-1:0] src_pay   [STAGES];

    logic [DEN_W-1:0] rem_next  [STAGES];
    logic [QUO_W-1:0] quo_next  [STAGES];

    // Stage inputs: the ports feed the first stage, each register the next.
    always_comb
    begin
        src_valid[0] = in_valid;
        src_rem[0]   = in_rem;
        src_quo[0]   = in_quo;
        src_pay[0]   = in_pay;
        for (int s = 1; s < STAGES; s++)
        begin
            src_valid[s] = valid_reg[s-1];
            src_rem[s]   = rem_reg[s-1];
            src_quo[s]   = quo_reg[s-1];
            src_pay[s]   = pay_reg[s-1];
        end
    end

    // Restoring steps of every stage.
    always_comb
    begin
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] rem_w;
        logic [QUO_W-1:0] quo_w;
        for (int s = 0; s < STAGES; s++)
        begin
            rem_w = src_rem[s];
            quo_w = src_quo[s];
            for (int b = 0; b < STEP_BITS; b++)
            begin
                trial = {rem_w, quo_w[QUO_W-1]};
                if (trial >= {1'b0, den})
                begin
                    trial = trial - {1'b0, den};
                    quo_w = {quo_w[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_w = {quo_w[QUO_W-2:0], 1'b0};
                end
                rem_w = trial[DEN_W-1:0];
            end
            rem_next[s] = rem_w;
            quo_next[s] = quo_w;
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (ce)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                valid_reg[s] <= src_valid[s];
            end
        end
    end

    // Data of the stages.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                pay_reg[s] <= src_pay[s];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_pay   = pay_reg[STAGES-1];

endmodule

`default_nettype wire

### design/difference_key_matte_top.sv
// ============================================================================
// difference_key_matte_top: per-pixel difference matte keyer
// Keys a foreground RGBA pixel against a background reference color and
// scales all four channels by the resulting matte.
// ============================================================================
//
//  Channel  Ports                        Beat contents (lowest bits first)
//  -------  ---------------------------  ------------------------------------------
//  input    s_tvalid s_tready s_tdata    color r g b a, key r g b
//  output   m_tvalid m_tready m_tdata    out r g b a, matte
//  config   cfg_we cfg_index cfg_data    0 tolerance, 1 falloff
//
// One pixel enters per clock unless the output stalls. Of the CHANNEL_BITS + 7
// register stages (23 at 16 bits), most are the one-bit-per-stage ramp divider;
// dividing the difference sum by three is one reciprocal multiplication stage.
// Reset clears all valid bits and loads both registers with their reset values.
// A stalled output beat freezes the whole pipeline; s_tready drops only then.
// ============================================================================
`default_nettype none

module difference_key_matte_top #(
    parameter int CHANNEL_BITS = dkm_pkg::CHANNEL_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // color_red, color_green, color_blue, color_alpha, key_red, key_green,
    // key_blue, zero fill
    input  wire logic [((7*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // out_red, out_green, out_blue, out_alpha, matte_value, zero fill
    output logic      [((5*CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [dkm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [CHANNEL_BITS-1:0]           cfg_data
);

    localparam int N       = CHANNEL_BITS;
    localparam int OUT_W   = ((5*CHANNEL_BITS+7)/8)*8;
    localparam int COLOR_W = 4*N;
    localparam int SUM_W   = N+2;
    // Reciprocal of three, rounded up; exact for every sum below 2^SUM_W.
    localparam int DIV3_S      = SUM_W + 2;
    localparam int DIV3_PROD_W = SUM_W + DIV3_S;
    localparam logic [DIV3_S-1:0] DIV3_MUL =
        DIV3_S'(((64'd1 << DIV3_S) / 64'd3) + 64'd1);
    localparam int RAMP_PAY_W = COLOR_W + 2;
    localparam logic [N-1:0] ONE = {N{1'b1}};

    // Divide a product of two channels by full scale, truncating.
    function automatic logic [N-1:0] div_by_one(input logic [2*N-1:0] prod);
        logic [N-1:0] q0;
        logic [N:0]   r0;
        logic [N:0]   q;
        q0 = prod[2*N-1:N];
        r0 = {1'b0, prod[N-1:0]} + {1'b0, q0};
        q  = {1'b0, q0} + ((r0 >= {1'b0, ONE}) ? (N+1)'(1) : (N+1)'(0));
        return q[N-1:0];
    endfunction

    logic ce;

    // Configuration registers.
    logic [N-1:0] tolerance_reg;
    logic [N-1:0] falloff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= N'(dkm_pkg::TOLERANCE_RESET);
            falloff_reg   <= N'(dkm_pkg::FALLOFF_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dkm_pkg::REG_TOLERANCE: tolerance_reg <= cfg_data;
                dkm_pkg::REG_FALLOFF:   falloff_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances unless a finished beat waits at the output.
    logic out_valid_reg;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    // Stage 1: absolute channel differences and their sum.
    logic [N-1:0]       in_cr, in_cg, in_cb, in_ca, in_kr, in_kg, in_kb;
    logic [N-1:0]       dr, dg, db;
    logic [SUM_W-1:0]   sum_next;
    logic               s1_valid_reg;
    logic [SUM_W-1:0]   s1_sum_reg;
    logic [COLOR_W-1:0] s1_color_reg;

    assign in_cr = s_tdata[0*N +: N];
    assign in_cg = s_tdata[1*N +: N];
    assign in_cb = s_tdata[2*N +: N];
    assign in_ca = s_tdata[3*N +: N];
    assign in_kr = s_tdata[4*N +: N];
    assign in_kg = s_tdata[5*N +: N];
    assign in_kb = s_tdata[6*N +: N];

    assign dr = (in_cr > in_kr) ? in_cr - in_kr : in_kr - in_cr;
    assign dg = (in_cg > in_kg) ? in_cg - in_kg : in_kg - in_cg;
    assign db = (in_cb > in_kb) ? in_cb - in_kb : in_kb - in_cb;
    assign sum_next = SUM_W'(dr) + SUM_W'(dg) + SUM_W'(db);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_sum_reg   <= sum_next;
            s1_color_reg <= {in_ca, in_cb, in_cg, in_cr};
        end
    end

    // Mean difference: the sum times the reciprocal of three.
    logic [DIV3_PROD_W-1:0] div3_prod;
    logic                   d3_valid_reg;
    logic [N-1:0]           d3_diff_reg;
    logic [COLOR_W-1:0]     d3_color_reg;

    assign div3_prod = DIV3_PROD_W'(s1_sum_reg) * DIV3_PROD_W'(DIV3_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d3_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            d3_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d3_diff_reg  <= div3_prod[DIV3_S +: N];
            d3_color_reg <= s1_color_reg;
        end
    end

    // Stage 2: classify against tolerance and the end of the falloff band.
    logic [N-1:0]       diff;
    logic [N:0]         band_end;
    logic               opaque_next;
    logic               zero_next;
    logic [N-1:0]       excess_next;
    logic               s2_valid_reg;
    logic               s2_opaque_reg;
    logic               s2_zero_reg;
    logic [N-1:0]       s2_excess_reg;
    logic [COLOR_W-1:0] s2_color_reg;

    assign diff        = d3_diff_reg;
    assign band_end    = {1'b0, tolerance_reg} + {1'b0, falloff_reg};
    assign opaque_next = {1'b0, diff} > band_end;
    assign zero_next   = (falloff_reg == '0) || (diff <= tolerance_reg);
    assign excess_next = diff - tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            s2_valid_reg <= d3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s2_opaque_reg <= opaque_next;
            s2_zero_reg   <= zero_next;
            s2_excess_reg <= excess_next;
            s2_color_reg  <= d3_color_reg;
        end
    end

    // Stage 3: ramp dividend, excess times full scale.
    logic [2*N-1:0]     num_next;
    logic               s3_valid_reg;
    logic [N-1:0]       s3_num_hi_reg;
    logic [N-1:0]       s3_num_lo_reg;
    logic [RAMP_PAY_W-1:0] s3_pay_reg;

    assign num_next = {s2_excess_reg, {N{1'b0}}} - (2*N)'(s2_excess_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s3_num_hi_reg <= num_next[2*N-1:N];
            s3_num_lo_reg <= num_next[N-1:0];
            s3_pay_reg    <= {s2_opaque_reg, s2_zero_reg, s2_color_reg};
        end
    end

    // Ramp divider; the excess passes the falloff only on opaque or zero beats, whose quotient is unused.
    logic                  rd_valid;
    logic [N-1:0]          rd_quo;
    logic [RAMP_PAY_W-1:0] rd_pay;

    dkm_div_pipe #(
        .DEN_W     (N),
        .QUO_W     (N),
        .STEP_BITS (1),
        .PAY_W     (RAMP_PAY_W)
    ) u_ramp_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s3_valid_reg),
        .in_rem    (s3_num_hi_reg),
        .in_quo    (s3_num_lo_reg),
        .den       (falloff_reg),
        .in_pay    (s3_pay_reg),
        .out_valid (rd_valid),
        .out_quo   (rd_quo),
        .out_pay   (rd_pay)
    );

    // Stage 4: alpha selection and matte.
    logic               rd_opaque;
    logic               rd_zero;
    logic [COLOR_W-1:0] rd_color;
    logic [N-1:0]       rd_ca;
    logic [N-1:0]       alpha;
    logic [N-1:0]       matte_next;
    logic               s4_valid_reg;
    logic [N-1:0]       s4_matte_reg;
    logic [COLOR_W-1:0] s4_color_reg;

    assign rd_opaque  = rd_pay[RAMP_PAY_W-1];
    assign rd_zero    = rd_pay[RAMP_PAY_W-2];
    assign rd_color   = rd_pay[COLOR_W-1:0];
    assign rd_ca      = rd_color[3*N +: N];
    assign alpha      = rd_opaque ? rd_ca : (rd_zero ? '0 : rd_quo);
    assign matte_next = (alpha < rd_ca) ? alpha : rd_ca;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            s4_valid_reg <= rd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s4_matte_reg <= matte_next;
            s4_color_reg <= rd_color;
        end
    end

    // Stage 5: channel products.
    logic               s5_valid_reg;
    logic [N-1:0]       s5_matte_reg;
    logic [2*N-1:0]     s5_prod_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s5_matte_reg <= s4_matte_reg;
            for (int c = 0; c < 4; c++)
            begin
                s5_prod_reg[c] <= (2*N)'(s4_color_reg[c*N +: N]) * (2*N)'(s4_matte_reg);
            end
        end
    end

    // Output register: products divided by full scale.
    logic [N-1:0] out_red_reg;
    logic [N-1:0] out_green_reg;
    logic [N-1:0] out_blue_reg;
    logic [N-1:0] out_alpha_reg;
    logic [N-1:0] out_matte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_red_reg   <= div_by_one(s5_prod_reg[0]);
            out_green_reg <= div_by_one(s5_prod_reg[1]);
            out_blue_reg  <= div_by_one(s5_prod_reg[2]);
            out_alpha_reg <= div_by_one(s5_prod_reg[3]);
            out_matte_reg <= s5_matte_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_matte_reg, out_alpha_reg, out_blue_reg,
                              out_green_reg, out_red_reg});

endmodule

`default_nettype wire
